FILE: hdl/centered_moving_average_assert.svh
// Assertion macros for the centered moving average block.
`ifndef CENTERED_MOVING_AVERAGE_ASSERT_SVH
`define CENTERED_MOVING_AVERAGE_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge of clk_i outside reset.
`define CMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds on a rising edge of clk_i outside reset.
`define CMA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CMA_ASSERT(lbl, prop, msg)
`define CMA_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hdl/cma_pkg.sv
// Shared types and constant of the centered moving average block.
package cma_pkg;

  // Width of the half window configuration register.
  localparam int CFG_W = 4;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_CHECK    = 7'b0000010,
    ST_SUM      = 7'b0000100,
    ST_SUM_WAIT = 7'b0001000,
    ST_DIV_INIT = 7'b0010000,
    ST_DIV      = 7'b0100000,
    ST_LOAD     = 7'b1000000
  } cma_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // accept an input beat
    logic win_setup;  // load window bounds of the oldest pending output
    logic clear;      // end of signal, drop history and pending count
    logic sum_step;   // read one history entry and advance the age
    logic div_init;   // load the divider from the window sum
    logic div_step;   // one restoring divide iteration
    logic out_load;   // move the quotient into the output register
  } cma_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;       // oldest pending output is due
    logic last_seen;  // current sample carried the last flag
    logic sum_last;   // read issued now is the window's last
    logic div_done;   // divide iteration issued now is the final one
    logic out_free;   // output register can take a new beat
  } cma_sts_t;

endpackage

FILE: hdl/centered_moving_average.sv
// Top level of the centered moving average filter with clipped window edges.
//
// Takes one signed sample per input beat and gives the truncated mean over the
// centered window of each sample, clipped at both ends of the signal; a beat with
// is_last_i flushes every pending mean, marks the final one with last_out_o and
// clears the history for the next signal. The block works on one sample at a
// time: a sample is accepted, then decided on, and each mean it releases then
// sums the clipped window of w entries (at most 2*half_width+1), read from the
// history memory one entry a cycle, and runs SUM_W = SAMPLE_BITS +
// clog2(2*MAX_HALF+2) iterations of the restoring divider (21 at the default
// sizes) before loading the output register. The next sample is taken while
// the last mean still waits in the output register. half_width is written
// through cfg_we_i / cfg_wdata_i and is used as min(half_width, MAX_HALF).
module centered_moving_average #(
  parameter int MAX_HALF    = 15,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: half window width
  input  logic                          cfg_we_i,
  input  logic [cma_pkg::CFG_W-1:0]     cfg_wdata_i,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          is_last_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] average_o,
  output logic                          last_out_o
);

  cma_pkg::cma_cmd_t cmd;
  cma_pkg::cma_sts_t sts;

  // Sequence the accept, window sum, divide and output load of each mean.
  cma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Hold the history, compute window bounds, accumulate and divide.
  cma_datapath #(
    .MAX_HALF    (MAX_HALF),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_i),
    .is_last_i   (is_last_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .average_o   (average_o),
    .last_out_o  (last_out_o)
  );

endmodule

FILE: hdl/cma_ctrl.sv
// Controller state machine of the centered moving average block.
module cma_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output cma_pkg::cma_cmd_t cmd_o,
  input  cma_pkg::cma_sts_t sts_i
);

  cma_pkg::cma_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cma_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      cma_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = cma_pkg::ST_CHECK;
        end
      end
      cma_pkg::ST_CHECK: begin
        if (sts_i.emit) begin
          cmd_o.win_setup = 1'b1;
          state_d         = cma_pkg::ST_SUM;
        end else begin
          cmd_o.clear = sts_i.last_seen;
          state_d     = cma_pkg::ST_IDLE;
        end
      end
      cma_pkg::ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (sts_i.sum_last) begin
          state_d = cma_pkg::ST_SUM_WAIT;
        end
      end
      cma_pkg::ST_SUM_WAIT: begin
        state_d = cma_pkg::ST_DIV_INIT;
      end
      cma_pkg::ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = cma_pkg::ST_DIV;
      end
      cma_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = cma_pkg::ST_LOAD;
        end
      end
      cma_pkg::ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = cma_pkg::ST_CHECK;
        end
      end
      default: begin
        state_d = cma_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/cma_datapath.sv
// Datapath: sample history, window bounds, accumulator, divider, output register.
`include "centered_moving_average_assert.svh"
module cma_datapath #(
  parameter int MAX_HALF    = 15,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cma_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          is_last_i,
  input  cma_pkg::cma_cmd_t             cmd_i,
  output cma_pkg::cma_sts_t             sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] average_o,
  output logic                          last_out_o
);

  localparam int HIST_DEPTH = 2 * MAX_HALF + 1;
  localparam int MAX_OUT    = MAX_HALF + 1;
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int PTR_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int SUM_W      = SAMPLE_BITS + CNT_W;
  localparam int DIV_W      = $clog2(SUM_W + 1);

  logic [cma_pkg::CFG_W-1:0] half_width_q;

  logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  logic                          rd_vld_q;

  logic [PTR_W-1:0] wp_q;
  logic [CNT_W-1:0] hv_q;
  logic [CNT_W-1:0] pend_q;
  logic             last_q;

  logic [CNT_W-1:0] k_q, hi_q, cnt_q;
  logic signed [SUM_W-1:0] sum_q;

  logic [SUM_W-1:0] quo_q;
  logic [CNT_W:0]   rem_q;
  logic             neg_q;
  logic [DIV_W-1:0] div_cnt_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] average_q;
  logic                          last_out_q;

  logic [CNT_W-1:0] h_val, d_val, lo_val, dh_val, hvm1_val, hi_val;
  logic [CNT_W:0]   addr_sum;
  logic [PTR_W-1:0] rd_addr;
  logic [CNT_W:0]   rem_sh;
  logic             q_bit;
  logic [CNT_W:0]   rem_nxt;

  // Window bounds of the oldest pending output, ages counted from the newest sample.
  always_comb begin
    h_val    = (int'(half_width_q) > MAX_HALF) ? CNT_W'(MAX_HALF) : CNT_W'(half_width_q);
    d_val    = pend_q - CNT_W'(1);
    lo_val   = (d_val > h_val) ? (d_val - h_val) : '0;
    dh_val   = d_val + h_val;
    hvm1_val = hv_q - CNT_W'(1);
    hi_val   = (dh_val > hvm1_val) ? hvm1_val : dh_val;
  end

  // Map an age onto the circular history.
  always_comb begin
    addr_sum = (CNT_W + 1)'(wp_q) + (CNT_W + 1)'(HIST_DEPTH - 1) - (CNT_W + 1)'(k_q);
    if (addr_sum >= (CNT_W + 1)'(HIST_DEPTH)) begin
      rd_addr = PTR_W'(addr_sum - (CNT_W + 1)'(HIST_DEPTH));
    end else begin
      rd_addr = PTR_W'(addr_sum);
    end
  end

  // One restoring divide iteration.
  always_comb begin
    rem_sh = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, cnt_q});
    if (q_bit) begin
      rem_nxt = rem_sh - {1'b0, cnt_q};
    end else begin
      rem_nxt = rem_sh;
    end
  end

  assign sts_o.emit      = (pend_q != '0) && (last_q || (d_val >= h_val));
  assign sts_o.last_seen = last_q;
  assign sts_o.sum_last  = (k_q == hi_q);
  assign sts_o.div_done  = (div_cnt_q == DIV_W'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      hist_mem[wp_q] <= sample_i;
    end
    rd_data_q <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= cma_pkg::CFG_W'(2);
      wp_q         <= '0;
      hv_q         <= '0;
      pend_q       <= '0;
      last_q       <= 1'b0;
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        half_width_q <= cfg_wdata_i;
      end
      rd_vld_q <= cmd_i.sum_step;
      if (cmd_i.take) begin
        wp_q   <= (wp_q == PTR_W'(HIST_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
        hv_q   <= (hv_q == CNT_W'(HIST_DEPTH)) ? hv_q : hv_q + CNT_W'(1);
        pend_q <= (pend_q == CNT_W'(MAX_OUT)) ? pend_q : pend_q + CNT_W'(1);
        last_q <= is_last_i;
      end else if (cmd_i.clear) begin
        wp_q   <= '0;
        hv_q   <= '0;
        pend_q <= '0;
      end else if (cmd_i.out_load) begin
        pend_q <= pend_q - CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Accumulate the window, run the divider and load the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.win_setup) begin
      k_q   <= lo_val;
      hi_q  <= hi_val;
      cnt_q <= hi_val - lo_val + CNT_W'(1);
      sum_q <= '0;
    end else begin
      if (cmd_i.sum_step) begin
        k_q <= k_q + CNT_W'(1);
      end
      if (rd_vld_q) begin
        sum_q <= sum_q + SUM_W'(rd_data_q);
      end
    end
    if (cmd_i.div_init) begin
      neg_q     <= sum_q[SUM_W-1];
      quo_q     <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
      rem_q     <= '0;
      div_cnt_q <= DIV_W'(SUM_W);
    end else if (cmd_i.div_step) begin
      quo_q     <= {quo_q[SUM_W-2:0], q_bit};
      rem_q     <= rem_nxt;
      div_cnt_q <= div_cnt_q - DIV_W'(1);
    end
    if (cmd_i.out_load) begin
      average_q  <= neg_q ? -quo_q[SAMPLE_BITS-1:0] : quo_q[SAMPLE_BITS-1:0];
      last_out_q <= last_q && (pend_q == CNT_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;
  assign last_out_o  = last_out_q;

  `CMA_ASSERT(a_pend_le_hist, pend_q <= hv_q, "pending outputs exceed held samples")
  `CMA_ASSERT(a_pend_max, int'(pend_q) <= MAX_OUT, "pending count above its bound")
  `CMA_NEVER(a_no_overwrite, cmd_i.out_load && out_valid_q && !out_ready_i, "output beat lost")
  `CMA_ASSERT(a_clear_state, cmd_i.clear |=> (pend_q == '0 && hv_q == '0), "clear missed")

endmodule
